[hdl/upd_pkg.sv]
// upd_pkg: shared types, character constants and pair-parsing functions
// for the percent decoder; no dependencies
package upd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] NUL_CHAR   = 8'h00;
  localparam int unsigned HexBase   = 16;

  // what is held back from earlier beats
  typedef enum logic [2:0] {
    HOLD_NONE = 3'b001,
    HOLD_PCT  = 3'b010,
    HOLD_PAIR = 3'b100
  } hold_t;

  // decoded bytes caused by one input beat, oldest in entry 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } pair_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == SPACE_CHAR) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == PLUS_CHAR) ? SPACE_CHAR : c;
  endfunction

  // strtol-style parse of the two bytes after a percent sign
  function automatic pair_t parse_pair(input logic [7:0] a, input logic [7:0] b);
    pair_t p;
    hex_t  ha;
    hex_t  hb;
    ha    = hex_value(a);
    hb    = hex_value(b);
    p.ok  = 1'b0;
    p.val = 8'd0;
    if (a == NUL_CHAR) begin
      p.ok = 1'b1;
    end else if (ha.ok) begin
      if (b == NUL_CHAR) begin
        p.ok  = 1'b1;
        p.val = {4'd0, ha.val};
      end else if (hb.ok) begin
        p.ok  = 1'b1;
        p.val = {ha.val, hb.val};
      end
    end else if (hb.ok) begin
      if (is_ws(a) || a == PLUS_CHAR) begin
        p.ok  = 1'b1;
        p.val = {4'd0, hb.val};
      end else if (a == MINUS_CHAR) begin
        p.ok  = 1'b1;
        p.val = 8'(8'd0 - {4'd0, hb.val});
      end
    end
    return p;
  endfunction

endpackage

[hdl/upd_front.sv]
// upd_front: accepts input beats, tracks held escape bytes and builds one
// job of up to three decoded bytes per beat; uses upd_pkg
module upd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          push,
  output upd_pkg::job_t job
);

  upd_pkg::hold_t held_count;
  upd_pkg::hold_t held_count_next;
  logic [7:0]     held_first;
  logic [7:0]     held_first_next;
  upd_pkg::pair_t pr;
  logic [2:0][7:0] em;
  logic [1:0]     n;

  assign pr = upd_pkg::parse_pair(held_first, in_byte);

  always_comb begin
    em              = '0;
    n               = 2'd0;
    held_count_next = held_count;
    held_first_next = held_first;
    unique case (held_count)
      upd_pkg::HOLD_PCT: begin
        held_first_next = in_byte;
        held_count_next = upd_pkg::HOLD_PAIR;
      end
      upd_pkg::HOLD_PAIR: begin
        held_count_next = upd_pkg::HOLD_NONE;
        if (pr.ok) begin
          em[n] = pr.val;
          n     = n + 2'd1;
        end else begin
          em[n] = upd_pkg::PCT_CHAR;
          n     = n + 2'd1;
          if (held_first == upd_pkg::PCT_CHAR) begin
            // second percent starts a fresh escape with this byte as its first
            held_first_next = in_byte;
            held_count_next = upd_pkg::HOLD_PAIR;
          end else begin
            em[n] = upd_pkg::plain(held_first);
            n     = n + 2'd1;
            if (in_byte == upd_pkg::PCT_CHAR) begin
              held_count_next = upd_pkg::HOLD_PCT;
            end else begin
              em[n] = upd_pkg::plain(in_byte);
              n     = n + 2'd1;
            end
          end
        end
      end
      default: begin
        held_count_next = upd_pkg::HOLD_NONE;
        if (in_byte == upd_pkg::PCT_CHAR) begin
          held_count_next = upd_pkg::HOLD_PCT;
        end else begin
          em[n] = upd_pkg::plain(in_byte);
          n     = n + 2'd1;
        end
      end
    endcase
    if (in_last) begin
      // flush whatever is still held
      if (held_count_next == upd_pkg::HOLD_PCT) begin
        em[n] = upd_pkg::PCT_CHAR;
        n     = n + 2'd1;
      end else if (held_count_next == upd_pkg::HOLD_PAIR) begin
        em[n] = upd_pkg::PCT_CHAR;
        n     = n + 2'd1;
        em[n] = upd_pkg::plain(held_first_next);
        n     = n + 2'd1;
      end
      held_count_next = upd_pkg::HOLD_NONE;
    end
  end

  assign push      = take && (n != 2'd0);
  assign job.bytes = em;
  assign job.cnt   = n;
  assign job.last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= upd_pkg::HOLD_NONE;
    end else if (take) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_first <= held_first_next;
    end
  end

endmodule

[hdl/upd_queue.sv]
// upd_queue: small first-in first-out queue of decode jobs between the
// front and back parts; uses upd_pkg
module upd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::job_t push_job,
  input  logic          pop,
  output logic          head_valid,
  output upd_pkg::job_t head_job,
  output logic          full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));
  assign head_job   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hdl/upd_back.sv]
// upd_back: walks the head job one byte per beat into the output register;
// uses upd_pkg
module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  upd_pkg::job_t head_job,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast,
  output logic          m_tuser
);

  logic [1:0] idx;
  logic       load;
  logic       fin;

  assign load = !m_tvalid || m_tready;
  assign fin  = (idx == head_job.cnt - 2'd1);
  assign pop  = load && head_valid && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        idx <= fin ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      m_tdata <= head_job.bytes[idx];
      m_tlast <= fin;
      m_tuser <= fin && head_job.last;
    end
  end

endmodule

[hdl/url_percent_decoder.sv]
// url_percent_decoder: top level of the streaming form-urlencoded decoder
// depends on upd_pkg, upd_front, upd_queue and upd_back
//
// usage:
//   input stream: one encoded byte per beat on s_tdata, s_tlast on the
//   final byte of a string. output stream: one decoded byte per beat on
//   m_tdata, m_tlast on the last byte produced by a given input beat,
//   m_tuser on the final decoded byte of the string.
//   "%XX" (and the strtol-style pair forms) collapse to one byte, '+'
//   becomes space, a pair that does not parse gives '%' and is rescanned.
//   bytes still held at string end are flushed unparsed ('+' as space).
// timing:
//   an input beat yields zero to three output beats. its job is written to
//   the job queue, and its first byte then to the output register (m_tvalid).
//   input beats are taken every cycle while the job queue has room; with
//   m_tready high the output side moves one byte per cycle, and as decoded
//   output never outgrows the input, this rate is sustained end to end.
//   the job queue (QUEUE_DEPTH entries) is the only stall point: s_tready
//   drops only when it is full, which happens when m_tready is held low.
// reset:
//   rst (synchronous) drops all held escape bytes, empties the queue and
//   clears m_tvalid; the block is ready the cycle after reset.
module url_percent_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic [0:0] m_tuser    // [0] string_end
);

  logic          take;
  logic          push;
  upd_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  upd_pkg::job_t head_job;
  logic          full;

  // front accepts whenever the queue can take a job
  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  upd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .push    (push),
    .job     (push_job)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (full)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser[0])
  );

endmodule
